/* design/integer_literal_parser_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the integer literal parser core.
// Both macros expect clk_i and rst_ni in scope.
// ---------------------------------------------------------------------------
`ifndef INTEGER_LITERAL_PARSER_CORE_ASSERT_SVH
`define INTEGER_LITERAL_PARSER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ILP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ilp_pkg.sv */
// ---------------------------------------------------------------------------
// ilp_pkg
// Types, codes and constants shared by the integer literal parser modules.
// ---------------------------------------------------------------------------
package ilp_pkg;

  localparam int unsigned ValueWidth   = 64;
  localparam int unsigned ValueBitsDef = 64;
  localparam int unsigned CharWidth    = 8;
  localparam int unsigned StatusWidth  = 4;
  localparam int unsigned DigitWidth   = 4;

  localparam logic [CharWidth-1:0] CharUnder = 8'h5F;
  localparam logic [CharWidth-1:0] CharZero  = 8'h30;
  localparam logic [CharWidth-1:0] CharX     = 8'h78;
  localparam logic [CharWidth-1:0] CharB     = 8'h62;
  localparam logic [CharWidth-1:0] CharO     = 8'h6F;

  localparam logic [StatusWidth-1:0] StOk          = 4'd0;
  localparam logic [StatusWidth-1:0] StNoDigits    = 4'd1;
  localparam logic [StatusWidth-1:0] StLeadZero    = 4'd2;
  localparam logic [StatusWidth-1:0] StBadDec      = 4'd3;
  localparam logic [StatusWidth-1:0] StBadPrefix   = 4'd4;
  localparam logic [StatusWidth-1:0] StBadHex      = 4'd5;
  localparam logic [StatusWidth-1:0] StBadBin      = 4'd6;
  localparam logic [StatusWidth-1:0] StBadOct      = 4'd7;
  localparam logic [StatusWidth-1:0] StEmptyPrefix = 4'd8;

  localparam logic [1:0] PosLast = 2'd2;

  typedef enum logic [2:0] {
    MODE_DEC  = 3'd0,
    MODE_HEX  = 3'd1,
    MODE_BIN  = 3'd2,
    MODE_OCT  = 3'd3,
    MODE_STOP = 3'd4,
    MODE_ERR  = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_BIN = 2'd2,
    RADIX_OCT = 2'd3
  } radix_e;

  // Control part of the per-literal state.
  typedef struct packed {
    mode_e                  mode;
    logic [1:0]             pos;
    logic                   lead_zero;
    logic [StatusWidth-1:0] err;
    logic                   after_prefix;
  } ilp_ctrl_t;

  // What one character does: the next control state and the digit to add.
  typedef struct packed {
    ilp_ctrl_t             next;
    logic                  acc_en;
    radix_e                radix;
    logic [DigitWidth-1:0] digit;
  } ilp_step_t;

  localparam ilp_ctrl_t CtrlReset = '{
    mode:         MODE_DEC,
    pos:          2'd0,
    lead_zero:    1'b0,
    err:          StOk,
    after_prefix: 1'b0
  };

endpackage

/* design/ilp_in_stage.sv */
// ---------------------------------------------------------------------------
// ilp_in_stage
// Input register: holds one character word until the core consumes it.
// ---------------------------------------------------------------------------
module ilp_in_stage (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ilp_pkg::CharWidth-1:0]  char_code_i,
  input  logic                           is_last_i,
  input  logic                           take_i,
  output logic                           valid_o,
  output logic [ilp_pkg::CharWidth-1:0]  char_o,
  output logic                           last_o
);

  logic                          valid_q;
  logic [ilp_pkg::CharWidth-1:0] char_q;
  logic                          last_q;

  assign in_ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_code_i;
      last_q <= is_last_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;
  assign last_o  = last_q;

endmodule

/* design/ilp_classify.sv */
// ---------------------------------------------------------------------------
// ilp_classify
// Character decoder: works out the next control state for one character
// and which digit, if any, goes into the accumulator.
// ---------------------------------------------------------------------------
module ilp_classify (
  input  ilp_pkg::ilp_ctrl_t            ctrl_i,
  input  logic [ilp_pkg::CharWidth-1:0] char_i,
  output ilp_pkg::ilp_step_t            step_o
);

  logic is_under;
  logic is_digit;
  logic is_lower;
  logic is_upper;
  logic is_alpha;
  logic is_hex_letter;
  logic is_bin;
  logic is_oct;
  logic lz;

  assign is_under      = (char_i == ilp_pkg::CharUnder);
  assign is_digit      = (char_i inside {[8'h30:8'h39]});
  assign is_lower      = (char_i inside {[8'h61:8'h7A]});
  assign is_upper      = (char_i inside {[8'h41:8'h5A]});
  assign is_alpha      = is_lower || is_upper;
  assign is_hex_letter = (char_i inside {[8'h61:8'h66], [8'h41:8'h46]});
  assign is_bin        = (char_i inside {[8'h30:8'h31]});
  assign is_oct        = (char_i inside {[8'h30:8'h37]});

  always_comb begin
    step_o        = '0;
    step_o.next   = ctrl_i;
    step_o.radix  = ilp_pkg::RADIX_DEC;
    step_o.acc_en = 1'b0;
    step_o.digit  = char_i[ilp_pkg::DigitWidth-1:0];
    lz            = ctrl_i.lead_zero;

    case (ctrl_i.mode)
      ilp_pkg::MODE_DEC: begin
        if (!is_under) begin
          lz = (ctrl_i.pos == 2'd0) ? (char_i == ilp_pkg::CharZero) : ctrl_i.lead_zero;
          step_o.next.lead_zero = lz;
          if (lz && ctrl_i.pos == 2'd1 && is_digit) begin
            step_o.next.err  = ilp_pkg::StLeadZero;
            step_o.next.mode = ilp_pkg::MODE_ERR;
          end else if (is_alpha) begin
            // Only a lowercase x, b or o right after a leading zero opens a prefix.
            if (!lz || ctrl_i.pos != 2'd1) begin
              step_o.next.err  = ilp_pkg::StBadDec;
              step_o.next.mode = ilp_pkg::MODE_ERR;
            end else if (char_i == ilp_pkg::CharX) begin
              step_o.next.mode = ilp_pkg::MODE_HEX;
            end else if (char_i == ilp_pkg::CharB) begin
              step_o.next.mode = ilp_pkg::MODE_BIN;
            end else if (char_i == ilp_pkg::CharO) begin
              step_o.next.mode = ilp_pkg::MODE_OCT;
            end else begin
              step_o.next.err  = ilp_pkg::StBadPrefix;
              step_o.next.mode = ilp_pkg::MODE_ERR;
            end
          end else if (!is_digit) begin
            step_o.next.mode = ilp_pkg::MODE_STOP;
            if (ctrl_i.pos == 2'd0) begin
              step_o.next.err = ilp_pkg::StNoDigits;
            end
          end else begin
            step_o.acc_en = 1'b1;
            step_o.radix  = ilp_pkg::RADIX_DEC;
          end
        end
      end
      ilp_pkg::MODE_HEX: begin
        step_o.next.after_prefix = 1'b1;
        step_o.radix             = ilp_pkg::RADIX_HEX;
        if (!is_under) begin
          if (is_digit) begin
            step_o.acc_en = 1'b1;
          end else if (is_hex_letter) begin
            step_o.acc_en = 1'b1;
            step_o.digit  = ilp_pkg::DigitWidth'(char_i[2:0]) + 4'd9;
          end else begin
            step_o.next.err  = ilp_pkg::StBadHex;
            step_o.next.mode = ilp_pkg::MODE_ERR;
          end
        end
      end
      ilp_pkg::MODE_BIN: begin
        step_o.next.after_prefix = 1'b1;
        step_o.radix             = ilp_pkg::RADIX_BIN;
        if (!is_under) begin
          if (is_bin) begin
            step_o.acc_en = 1'b1;
          end else begin
            step_o.next.err  = ilp_pkg::StBadBin;
            step_o.next.mode = ilp_pkg::MODE_ERR;
          end
        end
      end
      ilp_pkg::MODE_OCT: begin
        step_o.next.after_prefix = 1'b1;
        step_o.radix             = ilp_pkg::RADIX_OCT;
        if (!is_under) begin
          if (is_oct) begin
            step_o.acc_en = 1'b1;
          end else begin
            step_o.next.err  = ilp_pkg::StBadOct;
            step_o.next.mode = ilp_pkg::MODE_ERR;
          end
        end
      end
      default: begin
      end
    endcase

    // The position counts every character and stops at two.
    if (ctrl_i.pos != ilp_pkg::PosLast) begin
      step_o.next.pos = ctrl_i.pos + 2'd1;
    end
  end

endmodule

/* design/ilp_accum.sv */
// ---------------------------------------------------------------------------
// ilp_accum
// Shift-add accumulator step: acc * radix + digit, with a carry-out flag
// that tells whether the true result left the value width.
// ---------------------------------------------------------------------------
module ilp_accum #(
  parameter int unsigned VALUE_BITS = ilp_pkg::ValueBitsDef
) (
  input  logic [VALUE_BITS-1:0]             acc_i,
  input  ilp_pkg::radix_e                   radix_i,
  input  logic [ilp_pkg::DigitWidth-1:0]    digit_i,
  output logic [VALUE_BITS-1:0]             acc_o,
  output logic                              carry_o
);

  localparam int unsigned ExtBits = VALUE_BITS + ilp_pkg::DigitWidth;

  logic [ExtBits-1:0] ext;
  logic [ExtBits-1:0] dig;
  logic [ExtBits-1:0] wide;

  assign ext = ExtBits'(acc_i);
  assign dig = ExtBits'(digit_i);

  always_comb begin
    case (radix_i)
      ilp_pkg::RADIX_DEC: wide = (ext << 3) + (ext << 1) + dig;
      ilp_pkg::RADIX_HEX: wide = (ext << 4) + dig;
      ilp_pkg::RADIX_BIN: wide = (ext << 1) + dig;
      ilp_pkg::RADIX_OCT: wide = (ext << 3) + dig;
      default:            wide = ext;
    endcase
  end

  // The product fits at most four extra bits, so any of them set means overflow.
  assign acc_o   = wide[VALUE_BITS-1:0];
  assign carry_o = |wide[ExtBits-1:VALUE_BITS];

endmodule

/* design/integer_literal_parser_core.sv */
// A result word is registered once the last character leaves the input register.
// Throughput: one character per cycle unless a stalled result word holds it back.
// A stalled result word holds back only a following last character.
// Reset (rst_ni low, asynchronous) clears the parse state and empties both registers.
// ---------------------------------------------------------------------------
// integer_literal_parser_core
// Parses an integer literal one character word at a time, with decimal,
// hex, binary and octal forms, and emits value, status and overflow.
// ---------------------------------------------------------------------------
`include "integer_literal_parser_core_assert.svh"

module integer_literal_parser_core #(
  parameter int unsigned VALUE_BITS = ilp_pkg::ValueBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ilp_pkg::CharWidth-1:0]    char_code_i,
  input  logic                             is_last_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ilp_pkg::ValueWidth-1:0]   value_o,
  output logic [ilp_pkg::StatusWidth-1:0]  status_o,
  output logic                             overflow_o
);

  logic                          cur_valid;
  logic [ilp_pkg::CharWidth-1:0] cur_char;
  logic                          cur_last;
  logic                          take;

  ilp_pkg::ilp_ctrl_t ctrl_q;
  ilp_pkg::ilp_ctrl_t ctrl_d;
  logic [VALUE_BITS-1:0] acc_q;
  logic [VALUE_BITS-1:0] acc_d;
  logic ovf_q;
  logic ovf_d;

  ilp_pkg::ilp_step_t    step;
  logic [VALUE_BITS-1:0] acc_next;
  logic                  carry;

  logic                            out_valid_q;
  logic [ilp_pkg::ValueWidth-1:0]  value_q;
  logic [ilp_pkg::ValueWidth-1:0]  value_d;
  logic [ilp_pkg::StatusWidth-1:0] status_q;
  logic [ilp_pkg::StatusWidth-1:0] status_d;
  logic                            overflow_q;
  logic                            overflow_d;
  logic                            prefix_open;

  // A last character needs a free result register; any other one goes straight through.
  assign take = cur_valid && (!cur_last || !out_valid_q || out_ready_i);

  ilp_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .is_last_i   (is_last_i),
    .take_i      (take),
    .valid_o     (cur_valid),
    .char_o      (cur_char),
    .last_o      (cur_last)
  );

  ilp_classify u_classify (
    .ctrl_i (ctrl_q),
    .char_i (cur_char),
    .step_o (step)
  );

  ilp_accum #(
    .VALUE_BITS (VALUE_BITS)
  ) u_accum (
    .acc_i   (acc_q),
    .radix_i (step.radix),
    .digit_i (step.digit),
    .acc_o   (acc_next),
    .carry_o (carry)
  );

  always_comb begin
    ctrl_d = step.next;
    acc_d  = step.acc_en ? acc_next : acc_q;
    ovf_d  = ovf_q || (step.acc_en && carry);

    prefix_open = (ctrl_d.mode == ilp_pkg::MODE_HEX) || (ctrl_d.mode == ilp_pkg::MODE_BIN)
               || (ctrl_d.mode == ilp_pkg::MODE_OCT);
    status_d = ctrl_d.err;
    if (ctrl_d.err == ilp_pkg::StOk && prefix_open && !ctrl_d.after_prefix) begin
      status_d = ilp_pkg::StEmptyPrefix;
    end
    value_d    = (status_d == ilp_pkg::StOk) ? ilp_pkg::ValueWidth'(acc_d) : '0;
    overflow_d = (status_d == ilp_pkg::StOk) && ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= ilp_pkg::CtrlReset;
      acc_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (take) begin
      if (cur_last) begin
        ctrl_q <= ilp_pkg::CtrlReset;
        acc_q  <= '0;
        ovf_q  <= 1'b0;
      end else begin
        ctrl_q <= ctrl_d;
        acc_q  <= acc_d;
        ovf_q  <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && cur_last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && cur_last) begin
      value_q    <= value_d;
      status_q   <= status_d;
      overflow_q <= overflow_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;
  assign overflow_o  = overflow_q;

  `ILP_ASSERT_SAME(a_err_clears_value, out_valid_q && status_q != ilp_pkg::StOk,
    value_q == '0 && !overflow_q, "error result carries a nonzero value or overflow")
  `ILP_ASSERT_SAME(a_status_range, out_valid_q,
    status_q <= ilp_pkg::StEmptyPrefix, "result status out of range")
  `ILP_ASSERT_NEXT(a_state_cleared, take && cur_last,
    ctrl_q == ilp_pkg::CtrlReset && acc_q == '0 && !ovf_q,
    "parse state not cleared after last character")
  `ILP_ASSERT_SAME(a_stall_cause, !in_ready_o,
    cur_valid && cur_last && out_valid_q && !out_ready_i,
    "input stalled without a blocked last character")

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives literals into integer_literal_parser_core one character word at a
// time and checks every result word against a cycle-free parse of the same
// characters, or against the fixed result of a typed directed row, with random
// gaps on the input side and random stalls on the output side.
// ---------------------------------------------------------------------------
module tb;

  localparam int StallLimit   = 2000;
  localparam int RandomItems  = 750;
  localparam int CalmItems    = 650;
  localparam int DrainCycles  = 8;
  localparam int ReportLimit  = 10;

  localparam logic [7:0] CharOne   = "1";
  localparam logic [7:0] CharSeven = "7";
  localparam logic [7:0] CharNine  = "9";
  localparam logic [7:0] LowerA    = "a";
  localparam logic [7:0] LowerF    = "f";
  localparam logic [7:0] LowerZ    = "z";
  localparam logic [7:0] UpperA    = "A";
  localparam logic [7:0] UpperF    = "F";
  localparam logic [7:0] UpperZ    = "Z";

  typedef struct packed {
    logic [ilp_pkg::ValueWidth-1:0]  value;
    logic [ilp_pkg::StatusWidth-1:0] status;
    logic                            overflow;
  } parse_res_t;

  typedef struct {
    string      text;
    bit         typed;
    parse_res_t res;
  } lit_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic [ilp_pkg::CharWidth-1:0]   char_code_i = '0;
  logic                            is_last_i = 1'b0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic [ilp_pkg::ValueWidth-1:0]  value_o;
  logic [ilp_pkg::StatusWidth-1:0] status_o;
  logic                            overflow_o;

  // Mirror of the parse state.
  ilp_pkg::mode_e                  p_mode;
  logic [1:0]                      p_pos;
  logic                            p_lead;
  logic [ilp_pkg::ValueWidth-1:0]  p_acc;
  logic [ilp_pkg::StatusWidth-1:0] p_err;
  logic                            p_ovf;
  logic                            p_after;

  parse_res_t     due_results[$];
  parse_res_t     got_res;
  parse_res_t     want_res;
  logic [7:0]     lit_q[$];
  int             live_items = 0;
  int             fault_count = 0;
  int             stall_left = 0;
  int             quiet_cycles = 0;
  bit             calm = 1'b0;

  lit_row_t dir_rows [23] = '{
    '{"0",                       1'b1, '{'0, ilp_pkg::StOk, 1'b0}},
    '{"18446744073709551615",    1'b1, '{'1, ilp_pkg::StOk, 1'b0}},
    '{"18446744073709551616",    1'b1, '{'0, ilp_pkg::StOk, 1'b1}},
    '{"0xFFFF_ffff_FFFF_ffff",   1'b1, '{'1, ilp_pkg::StOk, 1'b0}},
    '{"0x1_0000_0000_0000_0000", 1'b1, '{'0, ilp_pkg::StOk, 1'b1}},
    '{"0b1011_0110",             1'b0, '{'0, ilp_pkg::StOk, 1'b0}},
    '{"0o1777777777777777777777", 1'b1, '{'1, ilp_pkg::StOk, 1'b0}},
    '{"0x",                      1'b1, '{'0, ilp_pkg::StEmptyPrefix, 1'b0}},
    '{"0b_",                     1'b0, '{'0, ilp_pkg::StOk, 1'b0}},
    '{"___",                     1'b1, '{'0, ilp_pkg::StOk, 1'b0}},
    '{"+5",                      1'b1, '{'0, ilp_pkg::StNoDigits, 1'b0}},
    '{"12+34",                   1'b0, '{'0, ilp_pkg::StOk, 1'b0}},
    '{"012",                     1'b1, '{'0, ilp_pkg::StLeadZero, 1'b0}},
    '{"0X1",                     1'b1, '{'0, ilp_pkg::StBadPrefix, 1'b0}},
    '{"12a",                     1'b1, '{'0, ilp_pkg::StBadDec, 1'b0}},
    '{"_0x1",                    1'b1, '{'0, ilp_pkg::StBadDec, 1'b0}},
    '{"0xg",                     1'b1, '{'0, ilp_pkg::StBadHex, 1'b0}},
    '{"0b2",                     1'b1, '{'0, ilp_pkg::StBadBin, 1'b0}},
    '{"0o8",                     1'b1, '{'0, ilp_pkg::StBadOct, 1'b0}},
    '{"\377",                    1'b1, '{'0, ilp_pkg::StNoDigits, 1'b0}},
    '{"7\200",                   1'b0, '{'0, ilp_pkg::StOk, 1'b0}},
    '{"0_1",                     1'b0, '{'0, ilp_pkg::StOk, 1'b0}},
    '{"0xAbCdEf09",              1'b0, '{'0, ilp_pkg::StOk, 1'b0}}
  };

  integer_literal_parser_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .is_last_i   (is_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .status_o    (status_o),
    .overflow_o  (overflow_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void clear_parse();
    p_mode  = ilp_pkg::MODE_DEC;
    p_pos   = 2'd0;
    p_lead  = 1'b0;
    p_acc   = '0;
    p_err   = ilp_pkg::StOk;
    p_ovf   = 1'b0;
    p_after = 1'b0;
  endfunction

  function automatic bit is_dig(logic [7:0] c);
    return c >= ilp_pkg::CharZero && c <= CharNine;
  endfunction

  function automatic void latch_err(logic [ilp_pkg::StatusWidth-1:0] code);
    p_err  = code;
    p_mode = ilp_pkg::MODE_ERR;
  endfunction

  // Multiply-add of one digit; anything carried past bit 63 marks overflow.
  function automatic void add_digit(int radix, logic [3:0] digit);
    logic [ilp_pkg::ValueWidth+3:0] wide;
    wide = {4'b0, p_acc} * radix + digit;
    if (wide[ilp_pkg::ValueWidth+3:ilp_pkg::ValueWidth] != '0) p_ovf = 1'b1;
    p_acc = wide[ilp_pkg::ValueWidth-1:0];
  endfunction

  // Applies one character word to the mirror; returns 1 when it closes a literal.
  function automatic bit parse_char(logic [7:0] c, logic last, output parse_res_t res);
    logic [ilp_pkg::StatusWidth-1:0] st;
    bit alpha;
    res   = '0;
    alpha = (c >= LowerA && c <= LowerZ) || (c >= UpperA && c <= UpperZ);
    case (p_mode)
      ilp_pkg::MODE_DEC: begin
        if (c != ilp_pkg::CharUnder) begin
          if (p_pos == 2'd0) p_lead = (c == ilp_pkg::CharZero);
          if (p_lead && p_pos == 2'd1 && is_dig(c)) begin
            latch_err(ilp_pkg::StLeadZero);
          end else if (alpha) begin
            if (!p_lead || p_pos != 2'd1) latch_err(ilp_pkg::StBadDec);
            else if (c == ilp_pkg::CharX) p_mode = ilp_pkg::MODE_HEX;
            else if (c == ilp_pkg::CharB) p_mode = ilp_pkg::MODE_BIN;
            else if (c == ilp_pkg::CharO) p_mode = ilp_pkg::MODE_OCT;
            else latch_err(ilp_pkg::StBadPrefix);
          end else if (!is_dig(c)) begin
            p_mode = ilp_pkg::MODE_STOP;
            if (p_pos == 2'd0) p_err = ilp_pkg::StNoDigits;
          end else begin
            add_digit(10, 4'(c - ilp_pkg::CharZero));
          end
        end
      end
      ilp_pkg::MODE_HEX: begin
        p_after = 1'b1;
        if (c != ilp_pkg::CharUnder) begin
          if (is_dig(c)) add_digit(16, 4'(c - ilp_pkg::CharZero));
          else if (c >= LowerA && c <= LowerF) add_digit(16, 4'(c - LowerA + 10));
          else if (c >= UpperA && c <= UpperF) add_digit(16, 4'(c - UpperA + 10));
          else latch_err(ilp_pkg::StBadHex);
        end
      end
      ilp_pkg::MODE_BIN: begin
        p_after = 1'b1;
        if (c != ilp_pkg::CharUnder) begin
          if (c == ilp_pkg::CharZero || c == CharOne) add_digit(2, 4'(c - ilp_pkg::CharZero));
          else latch_err(ilp_pkg::StBadBin);
        end
      end
      ilp_pkg::MODE_OCT: begin
        p_after = 1'b1;
        if (c != ilp_pkg::CharUnder) begin
          if (c >= ilp_pkg::CharZero && c <= CharSeven) begin
            add_digit(8, 4'(c - ilp_pkg::CharZero));
          end else begin
            latch_err(ilp_pkg::StBadOct);
          end
        end
      end
      default: ;
    endcase
    if (p_pos < ilp_pkg::PosLast) p_pos = p_pos + 2'd1;
    if (!last) return 1'b0;
    st = p_err;
    if (st == ilp_pkg::StOk && !p_after
        && p_mode inside {ilp_pkg::MODE_HEX, ilp_pkg::MODE_BIN, ilp_pkg::MODE_OCT})
      st = ilp_pkg::StEmptyPrefix;
    res.status   = st;
    res.value    = (st == ilp_pkg::StOk) ? p_acc : '0;
    res.overflow = (st == ilp_pkg::StOk) ? p_ovf : 1'b0;
    clear_parse();
    return 1'b1;
  endfunction

  // Called at a falling edge; returns at the falling edge after the last word.
  task automatic send_literal(input bit typed, input parse_res_t fixed);
    parse_res_t r;
    int gap;
    int i;
    for (i = 0; i < lit_q.size(); i++) begin
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_valid_i  = 1'b1;
      char_code_i = lit_q[i];
      is_last_i   = (i == lit_q.size() - 1);
      do @(posedge clk_i); while (!in_ready_o);
      live_items++;
      if (parse_char(char_code_i, is_last_i, r)) due_results.push_back(typed ? fixed : r);
      @(negedge clk_i);
    end
  endtask

  task automatic add_digits(input int n, input int radix);
    int v;
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) lit_q.push_back(ilp_pkg::CharUnder);
      v = $urandom_range(0, radix - 1);
      if (v < 10) lit_q.push_back(ilp_pkg::CharZero + 8'(v));
      else lit_q.push_back(($urandom_range(0, 1) ? UpperA : LowerA) + 8'(v - 10));
    end
  endtask

  // A well-formed literal in a random radix; one in ten is long, near or past the value width.
  task automatic build_form();
    bit long_one;
    long_one = ($urandom_range(0, 9) == 0);
    case ($urandom_range(0, 3))
      0: begin
        lit_q.push_back(ilp_pkg::CharZero + 8'($urandom_range(1, 9)));
        add_digits(long_one ? $urandom_range(18, 23) : $urandom_range(0, 7), 10);
      end
      1: begin
        lit_q.push_back(ilp_pkg::CharZero);
        lit_q.push_back(ilp_pkg::CharX);
        add_digits(long_one ? $urandom_range(15, 18) : $urandom_range(1, 8), 16);
      end
      2: begin
        lit_q.push_back(ilp_pkg::CharZero);
        lit_q.push_back(ilp_pkg::CharB);
        add_digits(long_one ? $urandom_range(62, 66) : $urandom_range(1, 12), 2);
      end
      default: begin
        lit_q.push_back(ilp_pkg::CharZero);
        lit_q.push_back(ilp_pkg::CharO);
        add_digits(long_one ? $urandom_range(20, 23) : $urandom_range(1, 8), 8);
      end
    endcase
  endtask

  task automatic make_literal();
    int n;
    lit_q.delete();
    case ($urandom_range(0, 11))
      0, 1, 2, 3, 4, 5, 6: build_form();
      7, 8: begin
        build_form();
        lit_q[$urandom_range(0, lit_q.size() - 1)] = 8'($urandom_range(0, 255));
      end
      9: begin
        n = $urandom_range(1, 6);
        repeat (n) lit_q.push_back(8'($urandom_range(0, 255)));
      end
      10: begin
        case ($urandom_range(0, 3))
          0: begin
            lit_q.push_back(ilp_pkg::CharZero);
            lit_q.push_back($urandom_range(0, 1) ? ilp_pkg::CharX : ilp_pkg::CharO);
          end
          1: begin
            lit_q.push_back(ilp_pkg::CharZero);
            lit_q.push_back(ilp_pkg::CharB);
            repeat ($urandom_range(1, 3)) lit_q.push_back(ilp_pkg::CharUnder);
          end
          2: begin
            lit_q.push_back(ilp_pkg::CharUnder);
            lit_q.push_back(ilp_pkg::CharZero);
            lit_q.push_back(ilp_pkg::CharX);
            lit_q.push_back(CharOne);
          end
          default: begin
            lit_q.push_back(ilp_pkg::CharZero);
            add_digits($urandom_range(1, 4), 10);
          end
        endcase
      end
      default: begin
        // Decimal digits cut short by punctuation or a high code, then junk.
        add_digits($urandom_range(0, 5), 10);
        lit_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(128, 255))
                                             : 8'($urandom_range(33, 47)));
        n = $urandom_range(0, 4);
        repeat (n) lit_q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic flag_fault(input string what, input logic [63:0] want, input logic [63:0] got);
    fault_count++;
    if (fault_count <= ReportLimit)
      $display("mismatch on %s at %0t: expected %h, got %h", what, $realtime, want, got);
  endtask

  // Result side: random stall bursts, no new ones once the run turns calm.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 6);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_res = '{value_o, status_o, overflow_o};
      if (due_results.size() == 0) begin
        flag_fault("unexpected result word", '0, {got_res.value});
      end else begin
        want_res = due_results.pop_front();
        if (got_res.value !== want_res.value)
          flag_fault("value", want_res.value, got_res.value);
        if (got_res.status !== want_res.status)
          flag_fault("status", 64'(want_res.status), 64'(got_res.status));
        if (got_res.overflow !== want_res.overflow)
          flag_fault("overflow", 64'(want_res.overflow), 64'(got_res.overflow));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int r;
    int k;
    clear_parse();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (r = 0; r < $size(dir_rows); r++) begin
      lit_q.delete();
      for (k = 0; k < dir_rows[r].text.len(); k++) lit_q.push_back(dir_rows[r].text[k]);
      send_literal(dir_rows[r].typed, dir_rows[r].res);
    end

    while (live_items < RandomItems) begin
      make_literal();
      send_literal(1'b0, '0);
      calm = (live_items >= CalmItems);
    end
    in_valid_i = 1'b0;

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* integer_literal_parser_core.f */
+incdir+design
design/ilp_pkg.sv
design/ilp_in_stage.sv
design/ilp_classify.sv
design/ilp_accum.sv
design/integer_literal_parser_core.sv
tb/sv/tb.sv
